// ===== hw/rtl/allfp_pkg.sv =====
package allfp_pkg;

  localparam int LINK_W = 6;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;

  typedef logic [LINK_W-1:0]        link_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OP_W-1:0]          op_t;
  typedef logic [ST_W-1:0]          status_t;
  typedef logic [CNT_W-1:0]         count_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_ALT    = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_NONE = 2'd2;

  typedef struct packed {
    logic  next_we;
    link_t next_waddr;
    link_t next_wdata;
    link_t next_raddr;
    logic  data_we;
    link_t data_waddr;
    data_t data_wdata;
    link_t data_raddr;
  } store_req_t;

  typedef struct packed {
    link_t next_rdata;
    data_t data_rdata;
  } store_rsp_t;

  function automatic logic in_pool(link_t x, link_t nodes);
    return x < nodes;
  endfunction

endpackage

// ===== hw/rtl/allfp_if.sv =====
interface allfp_req_if;
  logic               valid;
  logic               ready;
  allfp_pkg::op_t     op;
  logic               pred_none;
  allfp_pkg::idx_t    pred;
  allfp_pkg::data_t   item;
  allfp_pkg::idx_t    read_index;

  modport source(output valid, op, pred_none, pred, item, read_index, input ready);
  modport sink(input valid, op, pred_none, pred, item, read_index, output ready);
endinterface

interface allfp_rsp_if;
  logic               valid;
  logic               ready;
  allfp_pkg::status_t status;
  allfp_pkg::link_t   head;
  allfp_pkg::link_t   free_head;
  allfp_pkg::link_t   slot;
  allfp_pkg::data_t   node_value;
  allfp_pkg::link_t   node_link;
  allfp_pkg::count_t  removed_count;

  modport source(output valid, status, head, free_head, slot, node_value, node_link,
                 removed_count, input ready);
  modport sink(input valid, status, head, free_head, slot, node_value, node_link,
               removed_count, output ready);
endinterface

// ===== hw/rtl/allfp_store.sv =====
module allfp_store #(
  parameter int NODES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  allfp_pkg::store_req_t req,
  output allfp_pkg::store_rsp_t rsp
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  allfp_pkg::link_t next_mem [NODES];
  allfp_pkg::data_t data_mem [NODES];
  logic [NODES-1:0] next_vld;
  logic [NODES-1:0] data_vld;

  allfp_pkg::link_t next_q;
  logic [AW-1:0]    next_aq;
  logic             next_vq;
  allfp_pkg::data_t data_q;
  logic             data_vq;

  // valid bits stand in for the reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
      data_vld <= '0;
    end else begin
      if (req.next_we) begin
        next_vld[req.next_waddr[AW-1:0]] <= 1'b1;
      end
      if (req.data_we) begin
        data_vld[req.data_waddr[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_waddr[AW-1:0]] <= req.next_wdata;
    end
    if (req.data_we) begin
      data_mem[req.data_waddr[AW-1:0]] <= req.data_wdata;
    end
    next_q  <= next_mem[req.next_raddr[AW-1:0]];
    next_aq <= req.next_raddr[AW-1:0];
    next_vq <= next_vld[req.next_raddr[AW-1:0]];
    data_q  <= data_mem[req.data_raddr[AW-1:0]];
    data_vq <= data_vld[req.data_raddr[AW-1:0]];
  end

  assign rsp.next_rdata = next_vq ? next_q
                        : allfp_pkg::LINK_W'(next_aq) + allfp_pkg::LINK_W'(1);
  assign rsp.data_rdata = data_vq ? data_q : '1;

endmodule

// ===== hw/rtl/allfp_ctrl.sv =====
module allfp_ctrl #(
  parameter int NODES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  allfp_req_if.sink             req,
  allfp_rsp_if.source           rsp,
  output allfp_pkg::store_req_t store_req,
  input  allfp_pkg::store_rsp_t store_rsp
);

  localparam allfp_pkg::link_t NONE = allfp_pkg::LINK_W'(NODES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_INS1 = 4'd2;
  localparam logic [3:0] S_INS2 = 4'd3;
  localparam logic [3:0] S_INS3 = 4'd4;
  localparam logic [3:0] S_DELH = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_W1   = 4'd7;
  localparam logic [3:0] S_W2   = 4'd8;
  localparam logic [3:0] S_W3   = 4'd9;
  localparam logic [3:0] S_RD1  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state, state_next;

  allfp_pkg::op_t     op_q, op_q_next;
  logic               at_head, at_head_next;
  allfp_pkg::link_t   pred_q, pred_q_next;
  allfp_pkg::data_t   item_q, item_q_next;
  allfp_pkg::link_t   ridx, ridx_next;

  allfp_pkg::link_t   head, head_next;
  allfp_pkg::link_t   free_head, free_head_next;

  allfp_pkg::link_t   t, t_next;
  allfp_pkg::link_t   cur, cur_next;
  allfp_pkg::link_t   n2, n2_next;
  allfp_pkg::link_t   steps, steps_next;
  allfp_pkg::count_t  count, count_next;
  logic               removed, removed_next;

  allfp_pkg::status_t res_status, res_status_next;
  allfp_pkg::link_t   res_slot, res_slot_next;
  allfp_pkg::data_t   res_value, res_value_next;
  allfp_pkg::link_t   res_link, res_link_next;

  logic               out_valid, out_valid_next;
  logic               out_load;
  allfp_pkg::status_t out_status;
  allfp_pkg::link_t   out_head;
  allfp_pkg::link_t   out_free_head;
  allfp_pkg::link_t   out_slot;
  allfp_pkg::data_t   out_value;
  allfp_pkg::link_t   out_link;
  allfp_pkg::count_t  out_count;

  allfp_pkg::link_t   nrd;
  allfp_pkg::data_t   drd;

  assign nrd = store_rsp.next_rdata;
  assign drd = store_rsp.data_rdata;

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    at_head_next    = at_head;
    pred_q_next     = pred_q;
    item_q_next     = item_q;
    ridx_next       = ridx;
    head_next       = head;
    free_head_next  = free_head;
    t_next          = t;
    cur_next        = cur;
    n2_next         = n2;
    steps_next      = steps;
    count_next      = count;
    removed_next    = removed;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_value_next  = res_value;
    res_link_next   = res_link;
    out_load        = 1'b0;
    out_valid_next  = out_valid && !rsp.ready;
    store_req       = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_q_next    = req.op;
          at_head_next = req.pred_none;
          pred_q_next  = allfp_pkg::LINK_W'(req.pred);
          item_q_next  = req.item;
          ridx_next    = allfp_pkg::LINK_W'(req.read_index);
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        res_status_next = allfp_pkg::ST_DONE;
        res_slot_next   = NONE;
        res_value_next  = '0;
        res_link_next   = NONE;
        count_next      = '0;
        removed_next    = 1'b0;
        steps_next      = '0;
        case (op_q)
          allfp_pkg::OP_INSERT: begin
            if (!allfp_pkg::in_pool(free_head, NONE)) begin
              res_status_next = allfp_pkg::ST_FULL;
              state_next      = S_FIN;
            end else if (!at_head && !allfp_pkg::in_pool(pred_q, NONE)) begin
              res_status_next = allfp_pkg::ST_NONE;
              state_next      = S_FIN;
            end else begin
              t_next               = free_head;
              store_req.next_raddr = free_head;
              state_next           = S_INS1;
            end
          end
          allfp_pkg::OP_DELETE: begin
            if (!allfp_pkg::in_pool(head, NONE)) begin
              res_status_next = allfp_pkg::ST_NONE;
              state_next      = S_FIN;
            end else if (at_head) begin
              t_next               = head;
              store_req.next_raddr = head;
              state_next           = S_DELH;
            end else if (!allfp_pkg::in_pool(pred_q, NONE)) begin
              res_status_next = allfp_pkg::ST_NONE;
              state_next      = S_FIN;
            end else begin
              cur_next             = pred_q;
              store_req.next_raddr = pred_q;
              state_next           = S_W1;
            end
          end
          allfp_pkg::OP_ALT: begin
            cur_next   = head;
            state_next = S_WALK;
          end
          default: begin
            if (allfp_pkg::in_pool(ridx, NONE)) begin
              store_req.next_raddr = ridx;
              store_req.data_raddr = ridx;
              state_next           = S_RD1;
            end else begin
              res_status_next = allfp_pkg::ST_NONE;
              state_next      = S_FIN;
            end
          end
        endcase
      end
      S_INS1: begin
        free_head_next = nrd;
        if (at_head) begin
          store_req.next_we    = 1'b1;
          store_req.next_waddr = t;
          store_req.next_wdata = head;
          store_req.data_we    = 1'b1;
          store_req.data_waddr = t;
          store_req.data_wdata = item_q;
          head_next            = t;
          res_slot_next        = t;
          state_next           = S_FIN;
        end else begin
          store_req.next_raddr = pred_q;
          state_next           = S_INS2;
        end
      end
      S_INS2: begin
        store_req.next_we    = 1'b1;
        store_req.next_waddr = t;
        store_req.next_wdata = nrd;
        store_req.data_we    = 1'b1;
        store_req.data_waddr = t;
        store_req.data_wdata = item_q;
        state_next           = S_INS3;
      end
      S_INS3: begin
        store_req.next_we    = 1'b1;
        store_req.next_waddr = pred_q;
        store_req.next_wdata = t;
        res_slot_next        = t;
        state_next           = S_FIN;
      end
      S_DELH: begin
        head_next            = nrd;
        store_req.next_we    = 1'b1;
        store_req.next_waddr = t;
        store_req.next_wdata = free_head;
        free_head_next       = t;
        res_slot_next        = t;
        state_next           = S_FIN;
      end
      S_WALK: begin
        if (steps == NONE || !allfp_pkg::in_pool(cur, NONE)) begin
          res_status_next = removed ? allfp_pkg::ST_DONE : allfp_pkg::ST_NONE;
          state_next      = S_FIN;
        end else begin
          store_req.next_raddr = cur;
          state_next           = S_W1;
        end
      end
      S_W1: begin
        if (!allfp_pkg::in_pool(nrd, NONE)) begin
          res_status_next = (op_q == allfp_pkg::OP_ALT && removed) ? allfp_pkg::ST_DONE
                                                                   : allfp_pkg::ST_NONE;
          state_next      = S_FIN;
        end else begin
          t_next               = nrd;
          store_req.next_raddr = nrd;
          state_next           = S_W2;
        end
      end
      S_W2: begin
        store_req.next_we    = 1'b1;
        store_req.next_waddr = cur;
        store_req.next_wdata = nrd;
        n2_next              = nrd;
        state_next           = S_W3;
      end
      S_W3: begin
        store_req.next_we    = 1'b1;
        store_req.next_waddr = t;
        store_req.next_wdata = free_head;
        free_head_next       = t;
        if (op_q == allfp_pkg::OP_DELETE) begin
          res_slot_next = t;
          state_next    = S_FIN;
        end else begin
          count_next   = count + allfp_pkg::CNT_W'(1);
          removed_next = 1'b1;
          steps_next   = steps + allfp_pkg::LINK_W'(1);
          // self-linked node: its link now points at the old free head
          cur_next     = (t == cur) ? free_head : n2;
          state_next   = S_WALK;
        end
      end
      S_RD1: begin
        res_value_next = drd;
        res_link_next  = allfp_pkg::in_pool(nrd, NONE) ? nrd : NONE;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NONE;
      free_head <= '0;
      out_valid <= 1'b0;
      steps     <= '0;
      count     <= '0;
      removed   <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      out_valid <= out_valid_next;
      steps     <= steps_next;
      count     <= count_next;
      removed   <= removed_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    at_head    <= at_head_next;
    pred_q     <= pred_q_next;
    item_q     <= item_q_next;
    ridx       <= ridx_next;
    t          <= t_next;
    cur        <= cur_next;
    n2         <= n2_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_value  <= res_value_next;
    res_link   <= res_link_next;
    if (out_load) begin
      out_status    <= res_status;
      out_head      <= allfp_pkg::in_pool(head, NONE) ? head : NONE;
      out_free_head <= allfp_pkg::in_pool(free_head, NONE) ? free_head : NONE;
      out_slot      <= res_slot;
      out_value     <= res_value;
      out_link      <= res_link;
      out_count     <= count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.head          = out_head;
  assign rsp.free_head     = out_free_head;
  assign rsp.slot          = out_slot;
  assign rsp.node_value    = out_value;
  assign rsp.node_link     = out_link;
  assign rsp.removed_count = out_count;

endmodule

// ===== hw/rtl/array_linked_list_free_pool.sv =====
// Linked list kept in a pool of NODES nodes, with unused nodes chained on a
// free list. Channel req carries one op (insert, delete, delete every second
// node, read node) with its operands; channel rsp returns one result per op:
// status, list head, free head, affected slot, node data/link, removed count.
// An op is taken when req.valid and req.ready are high; req.ready is high
// only while the sequencer is idle, one op at a time.
// Delete every second node walks the list until it stops at a node with no
// successor (at most NODES removals). req.ready rises together with
// rsp.valid, so the block takes no new op while one is still in progress.
// Every step goes through the single read port of the link store, one
// dependent link lookup per step.
// The result sits in an output register; if rsp.ready is low the block still
// takes the next op and holds its result until the register frees.
// Reset (rst, synchronous) empties the list and chains all nodes on the free
// list in order, node data reading as all ones; this takes effect at once.
module array_linked_list_free_pool #(
  parameter int NODES = 32
) (
  input logic         clk,
  input logic         rst,
  allfp_req_if.sink   req,
  allfp_rsp_if.source rsp
);

  allfp_pkg::store_req_t store_req;
  allfp_pkg::store_rsp_t store_rsp;

  allfp_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .store_req(store_req),
    .store_rsp(store_rsp)
  );

  allfp_store #(
    .NODES(NODES)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .req(store_req),
    .rsp(store_rsp)
  );

  a_heads_bounded: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.head <= 6'(NODES)) && (rsp.free_head <= 6'(NODES)))
    else $error("head or free head beyond pool");

  a_slot_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != allfp_pkg::ST_DONE) |-> rsp.slot == 6'(NODES))
    else $error("slot reported for a failed op");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == allfp_pkg::ST_DONE) || (rsp.status == allfp_pkg::ST_FULL)
                  || (rsp.status == allfp_pkg::ST_NONE))
    else $error("bad status code");

  a_count_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.removed_count != '0) |-> rsp.status == allfp_pkg::ST_DONE)
    else $error("removals with failure status");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !store_req.next_we && !store_req.data_we)
    else $error("store write while idle");

endmodule

// ===== sim/array_linked_list_free_pool_tb.sv =====
`timescale 1ns / 100ps

module array_linked_list_free_pool_tb;

  localparam int               POOL     = 32;
  localparam allfp_pkg::link_t NIL      = allfp_pkg::link_t'(POOL);
  localparam int               WATCHDOG = 4000;
  localparam int               TAIL     = 200;
  localparam int               HOLD_LEN = 300;

  typedef struct {
    allfp_pkg::op_t   op;
    logic             pred_none;
    allfp_pkg::idx_t  pred;
    allfp_pkg::data_t item;
    allfp_pkg::idx_t  read_index;
  } cmd_t;

  typedef struct {
    allfp_pkg::status_t status;
    allfp_pkg::link_t   head;
    allfp_pkg::link_t   free_head;
    allfp_pkg::link_t   slot;
    allfp_pkg::data_t   node_value;
    allfp_pkg::link_t   node_link;
    allfp_pkg::count_t  removed_count;
  } res_t;

  typedef struct {
    cmd_t cmd;
    res_t res;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  allfp_req_if req();
  allfp_rsp_if rsp();

  array_linked_list_free_pool #(.NODES(POOL)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  // shadow of the node store
  allfp_pkg::data_t pool_data [POOL];
  allfp_pkg::link_t pool_next [POOL];
  allfp_pkg::link_t list_top;
  allfp_pkg::link_t free_top;

  job_t job_q[$];
  res_t result_q[$];
  job_t in_flight;

  int errors     = 0;
  bit req_took   = 1'b0;
  int send_idle  = 0;
  int recv_stall = 0;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int quiet      = 0;

  function automatic bit is_node(allfp_pkg::link_t x);
    return x < POOL;
  endfunction

  function automatic allfp_pkg::link_t detach_node(bit at_top, allfp_pkg::link_t p);
    allfp_pkg::link_t t;
    if (!is_node(list_top)) return NIL;
    if (at_top) begin
      t = list_top;
      list_top = pool_next[t];
    end else begin
      if (!is_node(p)) return NIL;
      t = pool_next[p];
      if (!is_node(t)) return NIL;
      pool_next[p] = pool_next[t];
    end
    pool_next[t] = free_top;
    free_top = t;
    return t;
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t             r;
    allfp_pkg::link_t t;
    allfp_pkg::link_t walk;
    int               cnt;
    r.status     = allfp_pkg::ST_DONE;
    r.slot       = NIL;
    r.node_value = '0;
    r.node_link  = NIL;
    cnt = 0;
    case (c.op)
      allfp_pkg::OP_INSERT: begin
        if (!is_node(free_top)) begin
          r.status = allfp_pkg::ST_FULL;
        end else if (!c.pred_none && !is_node(allfp_pkg::link_t'(c.pred))) begin
          r.status = allfp_pkg::ST_NONE;
        end else begin
          t = free_top;
          free_top = pool_next[t];
          pool_data[t] = c.item;
          if (c.pred_none) begin
            pool_next[t] = list_top;
            list_top = t;
          end else begin
            pool_next[t] = pool_next[c.pred];
            pool_next[c.pred] = t;
          end
          r.slot = t;
        end
      end
      allfp_pkg::OP_DELETE: begin
        r.slot = detach_node(c.pred_none, allfp_pkg::link_t'(c.pred));
        if (!is_node(r.slot)) r.status = allfp_pkg::ST_NONE;
      end
      allfp_pkg::OP_ALT: begin
        walk = list_top;
        for (int s = 0; s < POOL; s++) begin
          if (!is_node(walk)) break;
          if (!is_node(pool_next[walk])) break;
          void'(detach_node(1'b0, walk));
          cnt++;
          walk = pool_next[walk];
        end
        if (cnt == 0) r.status = allfp_pkg::ST_NONE;
      end
      default: begin
        r.node_value = pool_data[c.read_index];
        r.node_link  = is_node(pool_next[c.read_index]) ? pool_next[c.read_index] : NIL;
      end
    endcase
    r.head          = is_node(list_top) ? list_top : NIL;
    r.free_head     = is_node(free_top) ? free_top : NIL;
    r.removed_count = allfp_pkg::count_t'(cnt);
    return r;
  endfunction

  function automatic cmd_t cmd_of(allfp_pkg::op_t op, logic at_top, allfp_pkg::idx_t p,
                                  allfp_pkg::data_t d, allfp_pkg::idx_t ri);
    cmd_t c;
    c.op         = op;
    c.pred_none  = at_top;
    c.pred       = p;
    c.item       = d;
    c.read_index = ri;
    return c;
  endfunction

  task automatic queue_job(cmd_t c);
    job_t j;
    j.cmd = c;
    j.res = apply_cmd(c);
    job_q.push_back(j);
  endtask

  // random node currently on the list, or any index if the list is empty
  function automatic allfp_pkg::idx_t pick_member();
    allfp_pkg::idx_t  seen [POOL];
    int               n;
    allfp_pkg::link_t walk;
    n = 0;
    walk = list_top;
    while (is_node(walk) && n < POOL) begin
      seen[n] = walk[allfp_pkg::IDX_W-1:0];
      n++;
      walk = pool_next[walk];
    end
    if (n == 0) return allfp_pkg::idx_t'($urandom_range(POOL - 1));
    return seen[$urandom_range(n - 1)];
  endfunction

  task automatic queue_random(int n, int w_ins, int w_del, int w_alt);
    cmd_t c;
    int   roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < w_ins) c.op = allfp_pkg::OP_INSERT;
      else if (roll < w_ins + w_del) c.op = allfp_pkg::OP_DELETE;
      else if (roll < w_ins + w_del + w_alt) c.op = allfp_pkg::OP_ALT;
      else c.op = allfp_pkg::OP_READ;
      c.pred_none  = ($urandom_range(99) < 25);
      c.pred       = ($urandom_range(99) < 4) ? allfp_pkg::idx_t'($urandom_range(POOL - 1))
                                              : pick_member();
      c.item       = allfp_pkg::data_t'($urandom);
      c.read_index = $urandom_range(1) ? pick_member()
                                       : allfp_pkg::idx_t'($urandom_range(POOL - 1));
      if ($urandom_range(99) < 5) begin
        c.op         = allfp_pkg::op_t'($urandom_range(3));
        c.pred_none  = 1'($urandom_range(1));
        c.pred       = allfp_pkg::idx_t'($urandom);
        c.read_index = allfp_pkg::idx_t'($urandom);
      end
      queue_job(c);
    end
  endtask

  task automatic wait_drain();
    while (job_q.size() != 0 || result_q.size() != 0 || req.valid) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_took) begin
      req_took = 1'b0;
      if (job_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_flight = job_q.pop_front();
        req.valid      <= 1'b1;
        req.op         <= in_flight.cmd.op;
        req.pred_none  <= in_flight.cmd.pred_none;
        req.pred       <= in_flight.cmd.pred;
        req.item       <= in_flight.cmd.item;
        req.read_index <= in_flight.cmd.read_index;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response ready, with long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : mon
    res_t want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (req.valid && req.ready) begin
        result_q.push_back(in_flight.res);
        req_took = 1'b1;
        moved = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        moved = 1'b1;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: transfer with no result pending: expected none, actual status %0d",
                   $time, rsp.status);
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("head", 32'(want.head), 32'(rsp.head));
          check_field("free_head", 32'(want.free_head), 32'(rsp.free_head));
          check_field("slot", 32'(want.slot), 32'(rsp.slot));
          check_field("node_value", want.node_value, rsp.node_value);
          check_field("node_link", 32'(want.node_link), 32'(rsp.node_link));
          check_field("removed_count", 32'(want.removed_count), 32'(rsp.removed_count));
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
        $display("array_linked_list_free_pool_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    req.valid      = 1'b0;
    req.op         = allfp_pkg::OP_INSERT;
    req.pred_none  = 1'b0;
    req.pred       = '0;
    req.item       = '0;
    req.read_index = '0;
    rsp.ready      = 1'b0;
    for (int i = 0; i < POOL; i++) begin
      pool_data[i] = -1;
      pool_next[i] = allfp_pkg::link_t'(i + 1);
    end
    list_top = NIL;
    free_top = '0;

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed
    queue_job(cmd_of(allfp_pkg::OP_READ,   1'b0, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_READ,   1'b0, 5'd0,  32'sd0, 5'd31));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b1, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b0, 5'd5,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_ALT,    1'b0, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b1, 5'd31, 32'h7fffffff, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b1, 5'd0,  32'h80000000, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b0, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b0, 5'd1,  -32'sd1, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b0, 5'd2,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_ALT,    1'b1, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_READ,   1'b0, 5'd0,  32'sd0, 5'd0));
    // predecessors taken from the free list
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b0, 5'd20, 32'h55555555, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b0, 5'd21, 32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_READ,   1'b0, 5'd0,  32'sd0, 5'd21));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b0, free_top[allfp_pkg::IDX_W-1:0],
                     32'haaaaaaaa, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b0, list_top[allfp_pkg::IDX_W-1:0],
                     32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_DELETE, 1'b1, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_INSERT, 1'b1, 5'd0,  32'h0000ffff, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_ALT,    1'b0, 5'd0,  32'sd0, 5'd0));
    queue_job(cmd_of(allfp_pkg::OP_READ,   1'b0, 5'd0,  32'sd0, 5'd20));
    wait_drain();

    // no idling, insert heavy so the pool fills
    queue_random(300, 60, 15, 3);
    wait_drain();

    send_idle = 53;
    queue_random(300, 40, 35, 5);
    wait_drain();

    send_idle  = 0;
    recv_stall = 53;
    queue_random(300, 40, 35, 5);
    wait_drain();

    send_idle  = 10;
    recv_stall = 10;
    queue_random(300, 45, 30, 5);
    wait_drain();

    // long receiver hold-off while requests keep coming
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    queue_random(100, 50, 25, 5);
    wait_drain();

    // delete heavy to drain the list
    send_idle  = 10;
    recv_stall = 10;
    queue_random(200, 20, 55, 5);
    wait_drain();

    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("array_linked_list_free_pool_tb: PASS");
    end else begin
      $display("array_linked_list_free_pool_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== array_linked_list_free_pool.f =====
hw/rtl/allfp_pkg.sv
hw/rtl/allfp_if.sv
hw/rtl/allfp_store.sv
hw/rtl/allfp_ctrl.sv
hw/rtl/array_linked_list_free_pool.sv
sim/array_linked_list_free_pool_tb.sv
